/* rtl/prime_test_odd_trial_division_defines.svh */
// Assertion macros used by the RTL controller
`ifndef PRIME_TEST_ODD_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_TEST_ODD_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prime test: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prime test: next-cycle check failed");

`endif

/* rtl/ptd_pkg.sv */
package ptd_pkg;

    typedef struct packed {
        logic load;
        logic start_div;
        logic div_step;
        logic advance;
        logic set_verdict;
        logic verdict;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic trivial;
        logic trivial_prime;
        logic sq_gt_v;
        logic last_bit;
        logic rem_zero;
    } status_t;

    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned FIRST_SQUARE  = 9;
    localparam int unsigned DIVISOR_STEP  = 2;
    localparam int unsigned SQUARE_BIAS   = 4;

endpackage

/* rtl/prime_test_odd_trial_division.sv */
// Trial-division primality test.
// Request channel: value (signed, VALUE_WIDTH bits) with req_valid/req_stall;
// a transfer happens on a rising edge with req_valid high and req_stall low.
// Response channel: is_prime with rsp_valid/rsp_stall, one response per request.
// Negative values, 0, 1 and even values (2 among them) are decided in the
// check state without the divider. Odd values run one remainder per odd
// divisor d (3, 5, ...) while d*d <= value on a shared bit-serial divider.
// The divider loop sets the rate; one item is worked on at a time and
// req_stall stays high until it has been handed to the response register.
// The response register holds the result while rsp_stall is high; a finished
// item waits there for the receiver, and the next request is taken meanwhile.
// Reset returns the controller to idle and drops rsp_valid; no state is kept
// between items.
module prime_test_odd_trial_division #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   rsp_valid,
    input  logic                   rsp_stall,
    output logic                   is_prime
);

    ptd_pkg::cmd_t    cmd;
    ptd_pkg::status_t status;

    ptd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ptd_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .value    (value),
        .cmd      (cmd),
        .status   (status),
        .is_prime (is_prime)
    );

endmodule

/* rtl/ptd_dp.sv */
module ptd_dp #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   clk,
    input  logic [VALUE_WIDTH-1:0] value,
    input  ptd_pkg::cmd_t          cmd,
    output ptd_pkg::status_t       status,
    output logic                   is_prime
);

    localparam int MW = VALUE_WIDTH - 1;
    localparam int SW = VALUE_WIDTH + 2;
    localparam int CW = $clog2(MW);

    logic          neg_reg;
    logic [MW-1:0] v_reg;
    logic [VALUE_WIDTH-1:0] d_reg,   d_next;
    logic [SW-1:0]          sq_reg,  sq_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic verdict_reg, verdict_next;
    logic out_reg,     out_next;

    logic [VALUE_WIDTH-1:0] shifted;

    assign shifted = {rem_reg[VALUE_WIDTH-2:0], v_reg[cnt_reg]};

    always_comb
    begin
        d_next       = d_reg;
        sq_next      = sq_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        verdict_next = verdict_reg;
        out_next     = out_reg;
        if (cmd.load)
        begin
            d_next  = VALUE_WIDTH'(ptd_pkg::FIRST_DIVISOR);
            sq_next = SW'(ptd_pkg::FIRST_SQUARE);
        end
        if (cmd.start_div)
        begin
            rem_next = '0;
            cnt_next = CW'(MW - 1);
        end
        if (cmd.div_step)
        begin
            rem_next = (shifted >= d_reg) ? shifted - d_reg : shifted;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.advance)
        begin
            d_next  = d_reg + VALUE_WIDTH'(ptd_pkg::DIVISOR_STEP);
            sq_next = sq_reg + {d_reg, 2'b00} + SW'(ptd_pkg::SQUARE_BIAS);
        end
        if (cmd.set_verdict)
            verdict_next = cmd.verdict;
        if (cmd.load_out)
            out_next = verdict_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_WIDTH-1];
            v_reg   <= value[MW-1:0];
        end
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        verdict_reg <= verdict_next;
        out_reg     <= out_next;
    end

    assign status.trivial       = neg_reg || (v_reg <= MW'(1)) || !v_reg[0];
    assign status.trivial_prime = !neg_reg && (v_reg == MW'(2));
    assign status.sq_gt_v       = sq_reg > SW'(v_reg);
    assign status.last_bit      = (cnt_reg == '0);
    assign status.rem_zero      = (rem_reg == '0);
    assign is_prime             = out_reg;

endmodule

/* rtl/ptd_ctrl.sv */
`include "prime_test_odd_trial_division_defines.svh"

module ptd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  ptd_pkg::status_t  status,
    output ptd_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_TEST  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.trivial)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = status.trivial_prime;
                    state_next      = S_DONE;
                end
                else if (status.sq_gt_v)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.last_bit)
                    state_next = S_TEST;
            end
            S_TEST:
            begin
                if (status.rem_zero)
                begin
                    cmd.set_verdict = 1'b1;
                    cmd.verdict     = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PTD_ASSERT_NOW(a_load_out_free, clk, rst_n, cmd.load_out, !out_valid_reg || !rsp_stall)
    `PTD_ASSERT_NEXT(a_accept_check, clk, rst_n, req_valid && !req_stall, state_reg == S_CHECK)
    `PTD_ASSERT_NEXT(a_div_to_test, clk, rst_n, state_reg == S_DIV && status.last_bit, state_reg == S_TEST)
    `PTD_ASSERT_NEXT(a_load_out_valid, clk, rst_n, cmd.load_out, rsp_valid && state_reg == S_IDLE)

endmodule

/* tb/prime_test_odd_trial_division_tb.sv */
module prime_test_odd_trial_division_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH = 16;
    localparam int CLK_PERIOD = 4;
    localparam int RANDOM_ITEMS = 400;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [VALUE_WIDTH-1:0] value_t;

    typedef struct {
        value_t tested;
        bit     verdict;
    } verdict_t;

    class prime_scoreboard;
        verdict_t    verdicts_due[$];
        int unsigned requests;
        int unsigned responses;
        int unsigned primes_due;
        int unsigned mismatches;

        function bit primality_of(value_t v);
            int unsigned n;
            int unsigned d;
            n = 32'(v);
            if (v[VALUE_WIDTH-1])
                return 1'b0;
            if (n <= 1)
                return 1'b0;
            if (n == 2)
                return 1'b1;
            if (!v[0])
                return 1'b0;
            for (d = ptd_pkg::FIRST_DIVISOR; d * d <= n; d += ptd_pkg::DIVISOR_STEP)
            begin
                if (n % d == 0)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_request(value_t v);
            verdict_t e;
            e.tested = v;
            e.verdict = primality_of(v);
            verdicts_due.push_back(e);
            requests++;
            if (e.verdict)
                primes_due++;
        endfunction

        function void check_response(logic got);
            verdict_t e;
            responses++;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d arrived with nothing outstanding, is_prime=%b",
                             responses, got);
                return;
            end
            e = verdicts_due.pop_front();
            if (got !== e.verdict)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d for value %0d (0x%h): expected is_prime=%b, got %b",
                             responses, $signed(e.tested), e.tested, e.verdict, got);
            end
        endfunction

        function int unsigned pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   req_valid = 1'b0;
    logic   req_stall;
    value_t value = '0;
    logic   rsp_valid;
    logic   rsp_stall = 1'b0;
    logic   is_prime;

    prime_scoreboard sb = new();
    int unsigned cycles = 0;
    bit calm = 1'b0;

    value_t corner_values[$] = '{
        16'h8000, 16'hFFFF, 16'hAAAA, 16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5,
        16'd9, 16'd15, 16'd25, 16'd49, 16'd97, 16'd121, 16'd289, 16'h4000,
        16'h5555, 16'h7FFE, 16'h7FFF, 16'd32749, 16'd32761
    };

    prime_test_odd_trial_division #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .value    (value),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .is_prime (is_prime)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d verdicts outstanding", cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(30, 120);
    endfunction

    function automatic value_t pick_value();
        int unsigned a;
        int unsigned b;
        value_t v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = value_t'($urandom());
            3, 4, 5: v = value_t'($urandom_range(0, 16383) * 2 + 1);
            6: v = value_t'($urandom_range(0, 200));
            7:
            begin
                a = $urandom_range(1, 90) * 2 + 1;
                b = $urandom_range(a, 32767 / a) | 1;
                if (a * b > 32767)
                    b -= 2;
                v = value_t'(a * b);
            end
            8: v = value_t'(32'h7FFF - $urandom_range(0, 200));
            default: v = {1'b1, 15'($urandom())};
        endcase
        return v;
    endfunction

    task automatic send_value(input value_t v, input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            value <= value_t'($urandom());
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(v);
    endtask

    // hold the response side back in bursts
    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(is_prime);

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (corner_values[i])
            send_value(corner_values[i], pick_gap());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= 150 && i < 200);
            send_value(pick_value(), pick_gap());
        end
        calm = 1'b0;

        @(negedge clk);
        req_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d values tested (%0d expected prime), %0d verdicts checked in %0d cycles",
                 sb.requests, sb.primes_due, sb.responses, cycles);
        $display("corners: negatives, 0, 1, 2, even values, odd squares, top-of-range values");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
        begin
            $display("%0d mismatches", sb.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* prime_test_odd_trial_division.f */
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_dp.sv
rtl/ptd_ctrl.sv
rtl/prime_test_odd_trial_division.sv
tb/prime_test_odd_trial_division_tb.sv
